// ----- sv/foc_pkg.sv -----
// Shared types and constants for the flow owner cache.
package foc_pkg;

    localparam int ENTRIES_DEFAULT = 128;

    localparam logic [15:0] TCP_LIFETIME_RESET = 16'd1500;
    localparam logic [15:0] UDP_LIFETIME_RESET = 16'd5000;

    localparam logic [63:0] IPV4_ADDR_MASK = 64'hFFFF_FFFF_0000_0000;

    localparam logic [1:0] CMD_LOOKUP = 2'd0;
    localparam logic [1:0] CMD_STORE  = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    localparam logic REG_TCP_LIFETIME = 1'b0;
    localparam logic REG_UDP_LIFETIME = 1'b1;

    typedef struct packed {
        logic [31:0] stamp;
        logic        is_ipv6;
        logic        is_udp;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
        logic [15:0] port;
        logic [31:0] owner;
    } t_entry;

    typedef struct packed {
        logic        done;
        logic        found;
        logic [31:0] owner;
    } t_result;

endpackage

// ----- sv/foc_ram.sv -----
// Entry memory: one write port, one registered read port.
module foc_ram #(
    parameter int DEPTH = foc_pkg::ENTRIES_DEFAULT,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  foc_pkg::t_entry i_wdata,
    input  logic            i_re,
    input  logic [AW-1:0]   i_raddr,
    output foc_pkg::t_entry o_rdata
);

    foc_pkg::t_entry r_mem [DEPTH];
    foc_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/foc_ctrl.sv -----
// Scan sequencer: walks the entry memory for lookup and store, sweeps it for clear and after reset.
module foc_ctrl #(
    parameter int ENTRIES = foc_pkg::ENTRIES_DEFAULT,
    localparam int AW = $clog2(ENTRIES)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    output logic             o_busy,
    input  logic [1:0]       i_command,
    input  logic             i_is_ipv6,
    input  logic             i_is_udp,
    input  logic [63:0]      i_addr_high,
    input  logic [63:0]      i_addr_low,
    input  logic [15:0]      i_port,
    input  logic [31:0]      i_owner_id,
    input  logic [31:0]      i_now_ms,
    input  logic [15:0]      i_tcp_lifetime,
    input  logic [15:0]      i_udp_lifetime,
    output logic             o_ram_we,
    output logic [AW-1:0]    o_ram_waddr,
    output foc_pkg::t_entry  o_ram_wdata,
    output logic             o_ram_re,
    output logic [AW-1:0]    o_ram_raddr,
    input  foc_pkg::t_entry  i_ram_rdata,
    output foc_pkg::t_result o_result
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_CLEAR = 3'b100
    } t_state;

    localparam logic [AW-1:0] LAST_IDX = AW'(ENTRIES - 1);

    t_state           r_state, n_state;
    logic [1:0]       r_cmd, n_cmd;
    foc_pkg::t_entry  r_key, n_key;
    logic [15:0]      r_ttl, n_ttl;
    logic [AW-1:0]    r_raddr, n_raddr;
    logic             r_rvalid, n_rvalid;
    logic [AW-1:0]    r_ridx, n_ridx;
    logic [AW-1:0]    r_ptr, n_ptr;
    logic             r_clr_cmd, n_clr_cmd;
    foc_pkg::t_result r_result, n_result;

    logic [31:0]   age;
    logic          key_hit;
    logic          age_ok;
    logic          hit;
    logic          scan_last;
    logic [AW-1:0] raddr_inc;
    logic [AW-1:0] ptr_inc;

    assign key_hit = (i_ram_rdata.owner != 32'd0)
                  && (i_ram_rdata.is_ipv6 == r_key.is_ipv6)
                  && (i_ram_rdata.is_udp == r_key.is_udp)
                  && (i_ram_rdata.port == r_key.port)
                  && (i_ram_rdata.addr_high == r_key.addr_high)
                  && (i_ram_rdata.addr_low == r_key.addr_low);
    assign age       = r_key.stamp - i_ram_rdata.stamp;
    assign age_ok    = (age <= {16'd0, r_ttl});
    // store refreshes a matching entry whatever its age
    assign hit       = r_rvalid && key_hit && ((r_cmd != foc_pkg::CMD_LOOKUP) || age_ok);
    assign scan_last = r_rvalid && (r_ridx == LAST_IDX);
    assign raddr_inc = (r_raddr == LAST_IDX) ? '0 : r_raddr + AW'(1);
    assign ptr_inc   = (r_ptr == LAST_IDX) ? '0 : r_ptr + AW'(1);

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_key       = r_key;
        n_ttl       = r_ttl;
        n_raddr     = r_raddr;
        n_ptr       = r_ptr;
        n_clr_cmd   = r_clr_cmd;
        n_result    = '0;
        n_rvalid    = (r_state == S_SCAN);
        n_ridx      = r_raddr;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_ptr;
        o_ram_wdata = r_key;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_cmd           = i_command;
                    n_key.stamp     = i_now_ms;
                    n_key.is_ipv6   = i_is_ipv6;
                    n_key.is_udp    = i_is_udp;
                    n_key.addr_high = i_is_ipv6 ? i_addr_high
                                                : (i_addr_high & foc_pkg::IPV4_ADDR_MASK);
                    n_key.addr_low  = i_is_ipv6 ? i_addr_low : 64'd0;
                    n_key.port      = i_port;
                    n_key.owner     = i_owner_id;
                    n_ttl           = i_is_udp ? i_udp_lifetime : i_tcp_lifetime;
                    n_raddr         = '0;
                    case (i_command)
                        foc_pkg::CMD_LOOKUP: begin
                            n_state = S_SCAN;
                        end
                        foc_pkg::CMD_STORE: begin
                            if (i_owner_id != 32'd0) begin
                                n_state = S_SCAN;
                            end else begin
                                n_result.done = 1'b1;
                            end
                        end
                        foc_pkg::CMD_CLEAR: begin
                            n_state   = S_CLEAR;
                            n_ptr     = '0;
                            n_clr_cmd = 1'b1;
                        end
                        default: begin
                            n_result.done = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                n_raddr = raddr_inc;
                if (hit) begin
                    n_state        = S_IDLE;
                    n_result.done  = 1'b1;
                    n_result.found = 1'b1;
                    if (r_cmd == foc_pkg::CMD_LOOKUP) begin
                        n_result.owner = i_ram_rdata.owner;
                    end else begin
                        o_ram_we    = 1'b1;
                        o_ram_waddr = r_ridx;
                    end
                end else if (scan_last) begin
                    n_state       = S_IDLE;
                    n_result.done = 1'b1;
                    if (r_cmd == foc_pkg::CMD_STORE) begin
                        // no match: take the round-robin slot
                        o_ram_we    = 1'b1;
                        o_ram_waddr = r_ptr;
                        n_ptr       = ptr_inc;
                    end
                end
            end
            S_CLEAR: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = r_raddr;
                o_ram_wdata = '0;
                n_raddr     = raddr_inc;
                if (r_raddr == LAST_IDX) begin
                    n_state       = S_IDLE;
                    n_result.done = r_clr_cmd;
                    n_clr_cmd     = 1'b0;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_raddr   <= '0;
            r_rvalid  <= 1'b0;
            r_ptr     <= '0;
            r_clr_cmd <= 1'b0;
            r_result  <= '0;
        end else begin
            r_state   <= n_state;
            r_raddr   <= n_raddr;
            r_rvalid  <= n_rvalid;
            r_ptr     <= n_ptr;
            r_clr_cmd <= n_clr_cmd;
            r_result  <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_key  <= n_key;
        r_ttl  <= n_ttl;
        r_ridx <= n_ridx;
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_ram_re    = (r_state == S_SCAN);
    assign o_ram_raddr = r_raddr;
    assign o_result    = r_result;

    a_scan_write_is_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ram_we && r_state == S_SCAN) |-> (r_cmd == foc_pkg::CMD_STORE))
        else $error("entry written during a lookup scan");

    a_owner_needs_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_result.done && r_result.owner != 32'd0) |-> r_result.found)
        else $error("owner reported without a hit");

    a_scan_end_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && n_state == S_IDLE) |=> r_result.done)
        else $error("scan ended without a result beat");

    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr <= LAST_IDX)
        else $error("replacement pointer out of range");

endmodule

// ----- sv/flow_owner_cache_ttl.sv -----
// Top level of the flow owner cache: lifetime registers, scan sequencer and entry memory.
//
// A command is taken when start is high and busy is low. A lookup or store reads the
// entry memory one entry per cycle through its single read port and stops at the first
// match or after the last entry, keeping busy high; o_done carries the result beat in the
// first cycle with busy low. A store with owner zero and the unused command finish at
// once with a beat in the next cycle. Clear and the pass that follows reset sweep the
// memory one entry per cycle with busy high; only a clear command produces a beat.
// Results cannot be stalled.
module flow_owner_cache_ttl #(
    parameter int ENTRIES = foc_pkg::ENTRIES_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_command,
    input  logic        i_is_ipv6,
    input  logic        i_is_udp,
    input  logic [63:0] i_addr_high,
    input  logic [63:0] i_addr_low,
    input  logic [15:0] i_port,
    input  logic [31:0] i_owner_id,
    input  logic [31:0] i_now_ms,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    output logic        o_done,
    output logic        o_found,
    output logic [31:0] o_found_owner
);

    localparam int AW = $clog2(ENTRIES);

    logic [15:0] r_tcp_lifetime;
    logic [15:0] r_udp_lifetime;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    foc_pkg::t_entry  ram_wdata;
    logic             ram_re;
    logic [AW-1:0]    ram_raddr;
    foc_pkg::t_entry  ram_rdata;
    foc_pkg::t_result result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tcp_lifetime <= foc_pkg::TCP_LIFETIME_RESET;
            r_udp_lifetime <= foc_pkg::UDP_LIFETIME_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                foc_pkg::REG_TCP_LIFETIME: r_tcp_lifetime <= i_cfg_data;
                foc_pkg::REG_UDP_LIFETIME: r_udp_lifetime <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    foc_ctrl #(
        .ENTRIES(ENTRIES)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .o_busy         (busy),
        .i_command      (i_command),
        .i_is_ipv6      (i_is_ipv6),
        .i_is_udp       (i_is_udp),
        .i_addr_high    (i_addr_high),
        .i_addr_low     (i_addr_low),
        .i_port         (i_port),
        .i_owner_id     (i_owner_id),
        .i_now_ms       (i_now_ms),
        .i_tcp_lifetime (r_tcp_lifetime),
        .i_udp_lifetime (r_udp_lifetime),
        .o_ram_we       (ram_we),
        .o_ram_waddr    (ram_waddr),
        .o_ram_wdata    (ram_wdata),
        .o_ram_re       (ram_re),
        .o_ram_raddr    (ram_raddr),
        .i_ram_rdata    (ram_rdata),
        .o_result       (result)
    );

    foc_ram #(
        .DEPTH(ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_done        = result.done;
    assign o_found       = result.found;
    assign o_found_owner = result.owner;

endmodule
